[rtl/smx_pkg.sv]
// Shared types, constants and the 2^(i/256) table of the softmax normaliser.
// Used by smx_ctrl, smx_dpath and softmax_vector_normalizer_top.
package smx_pkg;

  localparam int LOGIT_W = 16;               // signed Q4.12 logit
  localparam int EXP_W   = 28;               // unsigned Q12.16 exponential
  localparam int SUM_W   = 32;               // running sum of exponentials
  localparam int FRAC_W  = 16;               // fraction bits of the probability
  localparam int Q_BITS  = 17;               // quotient bits, 65536 means 1.0
  localparam int DVD_W   = EXP_W + FRAC_W + 1;
  localparam int STEP_W  = $clog2(Q_BITS);
  localparam int TAB_W   = 17;               // unsigned Q1.16 table entry

  localparam logic signed [15:0]   LOG2E_Q14   = 16'sd23637;
  localparam logic [63:0]          ROOT256_Q31 = 64'd2153306067;
  localparam logic [EXP_W-1:0]     EXP_MAX     = {EXP_W{1'b1}};
  localparam logic [Q_BITS-1:0]    PROB_ONE    = Q_BITS'(1 << FRAC_W);

  typedef logic [TAB_W-1:0] pow2_tab_t [256];

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // register the product of an accepted logit
    logic absorb;    // form the exponential, store it and add it up
    logic rd;        // read the stored exponential at the output index
    logic load;      // load the divider from the read data
    logic step;      // one restoring division step
    logic put;       // write the result into the output register
    logic finish;    // clear the vector state after its last result
  } smx_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;        // the captured logit ends its vector
    logic div_done;    // the division step in progress is the last one
    logic final_item;  // the output index points at the last stored entry
    logic out_free;    // the output register can take a result
  } smx_sts_t;

  // 2^(i/256) in Q1.16, built by repeated multiplication by 2^(1/256) in Q.31.
  function automatic pow2_tab_t pow2_build();
    pow2_tab_t   tab;
    logic [95:0] acc;
    acc = 96'd1 << 31;
    for (int i = 0; i < 256; i++) begin
      tab[i] = TAB_W'((acc + (96'd1 << 14)) >> 15);
      acc    = (acc * 96'(ROOT256_Q31) + (96'd1 << 30)) >> 31;
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = pow2_build();

endpackage

[rtl/smx_ctrl.sv]
// Sequencer of the softmax normaliser: takes logits in, then walks the stored
// exponentials through the divider. Depends on smx_pkg.
module smx_ctrl import smx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  smx_sts_t sts,
  output smx_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXP  = 6'b000010,
    S_READ = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_PUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        cmd.absorb = 1'b1;
        state_nxt  = sts.last ? S_READ : S_IDLE;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.put = 1'b1;
          if (sts.final_item) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/smx_dpath.sv]
// Datapath of the softmax normaliser: exponential unit, exponential store,
// running sum, restoring divider and output register. Depends on smx_pkg.
module smx_dpath import smx_pkg::*; #(
  parameter int VEC_MAX = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  smx_cmd_t            cmd,
  output smx_sts_t            sts,
  input  logic [LOGIT_W-1:0]  in_logit,
  input  logic                in_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [Q_BITS-1:0]   out_prob,
  output logic                out_final,
  output logic                out_trunc
);

  localparam int CNT_W = $clog2(VEC_MAX + 1);
  localparam int IDX_W = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1;

  logic signed [31:0]  prod_r, prod_nxt;
  logic                last_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    total_r;
  logic                ovf_r;
  logic [IDX_W-1:0]    idx_r;
  logic [EXP_W-1:0]    rdata_r;
  logic [EXP_W-1:0]    mem [VEC_MAX];

  logic [SUM_W-1:0]    div_d_r;
  logic [SUM_W-1:0]    div_rem_r, div_rem_nxt;
  logic [Q_BITS-1:0]   div_lo_r;
  logic [Q_BITS-1:0]   div_q_r;
  logic [STEP_W-1:0]   step_r;

  logic                out_valid_r;
  logic [Q_BITS-1:0]   out_prob_r, prob_nxt;
  logic                out_final_r;
  logic                out_trunc_r;

  logic signed [31:0]  y_sum;
  logic signed [5:0]   exp_n;
  logic [7:0]          tab_idx;
  logic [TAB_W-1:0]    tab_val;
  logic [5:0]          shr_amt;
  logic [47:0]         shl_val, shr_val;
  logic [EXP_W-1:0]    exp_val;
  logic [SUM_W:0]      sum_ext;
  logic                full;
  logic                final_item;
  logic [DVD_W-1:0]    dividend;
  logic [SUM_W:0]      cand, diff;
  logic                ge;

  assign prod_nxt = 32'(signed'(in_logit)) * 32'(LOG2E_Q14);

  // y = round(x * log2(e)) in Q.16; its integer part shifts a 2^fraction entry.
  always_comb begin
    y_sum   = prod_r + 32'sd512;
    exp_n   = y_sum[31:26];
    tab_idx = y_sum[25:18];
    tab_val = POW2_TAB[tab_idx];
    shr_amt = 6'(~exp_n + 6'sd1);
    shl_val = {31'b0, tab_val} << exp_n[4:0];
    shr_val = ({31'b0, tab_val} + (48'd1 << (shr_amt - 6'd1))) >> shr_amt;
    if (!exp_n[5]) begin
      exp_val = (shl_val > 48'(EXP_MAX)) ? EXP_MAX : shl_val[EXP_W-1:0];
    end else begin
      exp_val = shr_val[EXP_W-1:0];
    end
  end

  assign full    = (cnt_r == CNT_W'(VEC_MAX));
  assign sum_ext = {1'b0, total_r} + (SUM_W + 1)'(exp_val);

  assign final_item = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);

  assign dividend = {1'b0, rdata_r, {FRAC_W{1'b0}}} + DVD_W'(total_r >> 1);

  always_comb begin
    cand        = {div_rem_r, div_lo_r[Q_BITS-1]};
    diff        = cand - {1'b0, div_d_r};
    ge          = (cand >= {1'b0, div_d_r});
    div_rem_nxt = ge ? diff[SUM_W-1:0] : cand[SUM_W-1:0];
  end

  always_comb begin
    if (div_d_r == '0) begin
      prob_nxt = '0;
    end else if (div_q_r > PROB_ONE) begin
      prob_nxt = PROB_ONE;
    end else begin
      prob_nxt = div_q_r;
    end
  end

  always_comb begin
    sts.last       = last_r;
    sts.div_done   = (step_r == STEP_W'(Q_BITS - 1));
    sts.final_item = final_item;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.absorb) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          cnt_r   <= cnt_r + CNT_W'(1);
          total_r <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        end
      end
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.put) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_item ? '0 : idx_r + IDX_W'(1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        cnt_r   <= '0;
        total_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  // Payload registers and the exponential store.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prod_r <= prod_nxt;
      last_r <= in_last;
    end
    if (cmd.absorb && !full) begin
      mem[cnt_r[IDX_W-1:0]] <= exp_val;
    end
    if (cmd.rd) begin
      rdata_r <= mem[idx_r];
    end
    if (cmd.load) begin
      div_d_r   <= total_r;
      div_rem_r <= SUM_W'(dividend[DVD_W-1:Q_BITS]);
      div_lo_r  <= dividend[Q_BITS-1:0];
    end else if (cmd.step) begin
      div_rem_r <= div_rem_nxt;
      div_lo_r  <= {div_lo_r[Q_BITS-2:0], 1'b0};
      div_q_r   <= {div_q_r[Q_BITS-2:0], ge};
    end
    if (cmd.put) begin
      out_prob_r  <= prob_nxt;
      out_final_r <= final_item;
      out_trunc_r <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_prob  = out_prob_r;
  assign out_final = out_final_r;
  assign out_trunc = out_trunc_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VEC_MAX))
    else $error("element count beyond buffer depth");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && (div_d_r != '0) |-> (div_rem_r < div_d_r))
    else $error("divider remainder not below divisor");

  a_put_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |=> out_valid_r)
    else $error("result written but not offered");

  a_finish_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (cnt_r == '0) && (total_r == '0) && !ovf_r)
    else $error("vector state not cleared after its last result");

endmodule

[rtl/softmax_vector_normalizer_top.sv]
// Softmax normaliser over vectors of signed Q4.12 logits.
// Input channel: one logit per item, tlast on the last element of a vector.
// Output channel: one Q1.16 probability per stored element, in input order,
// tlast on the last of the vector, tuser set when elements were dropped
// because the vector was longer than VEC_MAX.
// Each input item is taken in turn: first the product with log2(e) is registered,
// then the exponential is formed, stored and added to the running sum, and no
// new logit is taken before that. After the last element each result is built
// from a store read, a divider load and 17 steps of the bit-serial divider,
// then written into the output register once the receiver can take it.
// No input is taken while the results of a vector are being produced. When
// the receiver stalls, the finished result waits in the output register and
// the sequencer holds before the next one; the last result may still wait
// while the first logit of the next vector is taken.
// Reset (rst_n low, synchronous) empties the vector state and drops any
// pending result.
// Depends on smx_pkg, smx_ctrl and smx_dpath.
module softmax_vector_normalizer_top import smx_pkg::*; #(
  parameter int VEC_MAX = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] logit
  input  logic        in_tlast,   // end_of_vector
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] probability, [23:17] zero
  output logic        out_tlast,  // final_result
  output logic [0:0]  out_tuser   // [0] truncated
);

  smx_cmd_t          cmd;
  smx_sts_t          sts;
  logic [Q_BITS-1:0] prob;
  logic              trunc;

  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smx_dpath #(
    .VEC_MAX (VEC_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_logit  (in_tdata),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_prob  (prob),
    .out_final (out_tlast),
    .out_trunc (trunc)
  );

  assign out_tdata = {{(24 - Q_BITS){1'b0}}, prob};
  assign out_tuser = trunc;

endmodule
